// ===== sv/fprt_pkg.sv =====
// Shared types and constants for the fixed-priority response-time block.
`timescale 1ns / 1ps

package fprt_pkg;

  // Most results emitted for one task set.
  localparam int RESULT_CAP = 16;

  // Status of the shared divider, as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== sv/fprt_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fprt_div #(
  parameter int W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [W:0]         dividend,
  input  logic [W-1:0]       divisor,
  output logic [W:0]         quotient,
  output fprt_pkg::div_status_t status
);

  localparam int CNT_W = $clog2(W + 2);

  logic [W:0]       rem;
  logic [W:0]       quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [W:0]       trial;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {rem[W-1:0], quo[W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W + 1);
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
          quo <= {quo[W-1:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[W-1:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== sv/fixed_priority_response_time_top.sv =====
// Top level of the fixed-priority response-time analysis block.
`timescale 1ns / 1ps
//
// Usage: load tasks one transaction at a time with start while busy is low;
// each transaction carries C, D, T, a priority and last_task. A non-final
// task is stored and busy stays low, so loading runs at one
// transaction per cycle. Tasks beyond TASK_SLOTS are dropped and flagged.
// The transaction marked last_task raises busy and runs the analysis:
//   sort:     one priority compare per pair (rank count).
//   analysis: per interference term the bit-serial divider computes
//             ceil(R/T); the number of terms depends on how many
//             iterations each task needs to converge.
//   emission: each result is read, then presented; at most sixteen results.
// Each result appears for one cycle with valid high, in priority order;
// all_feasible covers the whole set and last marks the final result.
// The receiver cannot stall: results are simply presented and go.
// Reset (synchronous, active high) empties the task set and returns the
// sequencer to idle; the task memories themselves are not cleared.

module fixed_priority_response_time_top #(
  parameter int TASK_SLOTS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] exec_time,
  input  logic [15:0] deadline,
  input  logic [15:0] period,
  input  logic [7:0]  priority_req,
  input  logic        last_task,
  output logic        valid,
  output logic [3:0]  sorted_rank,
  output logic [3:0]  task_index,
  output logic [15:0] resp_ticks,
  output logic        deadline_miss,
  output logic        all_feasible,
  output logic        set_overflow,
  output logic        last
);

  localparam int TB = TIME_BITS;
  localparam int IW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int SW = 2 * TB + 1;

  typedef enum logic [3:0] {
    IDLE, S_RDI, S_RDJ, S_CMPJ,
    A_RDI, A_LDI, A_RDJ, A_LDJ, A_DIV, A_MUL, A_ADD,
    E_RD, E_OUT
  } state_t;

  state_t state;

  // Load-order task store.
  logic [TB-1:0] tm_c [TASK_SLOTS];
  logic [TB-1:0] tm_d [TASK_SLOTS];
  logic [TB-1:0] tm_t [TASK_SLOTS];
  logic [7:0]    tm_p [TASK_SLOTS];
  // Priority-ordered copy.
  logic [TB-1:0] sm_c [TASK_SLOTS];
  logic [TB-1:0] sm_d [TASK_SLOTS];
  logic [TB-1:0] sm_t [TASK_SLOTS];
  logic [IW-1:0] sm_i [TASK_SLOTS];
  // Per-rank results.
  logic [TB-1:0] rm_r [TASK_SLOTS];
  logic          rm_m [TASK_SLOTS];

  logic [TB-1:0] rda_c, rda_d, rda_t;
  logic [7:0]    rda_p, rdb_p;
  logic [TB-1:0] sq_c, sq_d, sq_t;
  logic [IW-1:0] sq_i;
  logic [TB-1:0] rq_r;
  logic          rq_m;

  logic [CW-1:0] count, n, emit;
  logic          ovf, feas;
  logic [CW-1:0] si, sj;
  logic [IW-1:0] rank;
  logic [CW-1:0] ai, aj, er;
  logic [TB-1:0] resp, ci, di, cj, q;
  logic [SW-1:0] nxt;
  logic [2*TB-1:0] prod;
  logic [IW-1:0] s_addr;

  logic [TB-1:0] t_in;
  logic          before_i;
  logic [IW-1:0] rank_final;
  logic [SW-1:0] sum;
  logic [CW-1:0] n_next;

  logic                  div_start;
  logic [TB:0]           div_dividend;
  logic [TB:0]           div_quo;
  fprt_pkg::div_status_t div_st;

  fprt_div #(.W(TB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sq_t),
    .quotient (div_quo),
    .status   (div_st)
  );

  // Kick off ceil(R/T) as floor((R+T-1)/T) once T_j is read.
  assign div_start    = (state == A_LDJ);
  assign div_dividend = (TB+1)'(resp) + (TB+1)'(sq_t) - (TB+1)'(1);

  assign busy = (state != IDLE);

  always_comb begin
    t_in = TB'(period);
    if (t_in == '0) begin
      t_in = TB'(1);
    end
  end

  // Task j ranks ahead of task i: higher priority, or equal and loaded first.
  assign before_i   = (rdb_p > rda_p) || ((rdb_p == rda_p) && (sj < si));
  assign rank_final = rank + IW'(before_i);
  assign sum        = nxt + SW'(prod);
  assign n_next     = (count < CW'(TASK_SLOTS)) ? count + CW'(1) : count;

  // Single read address for the sorted store and the result store.
  always_comb begin
    case (state)
      A_RDI:   s_addr = ai[IW-1:0];
      A_RDJ:   s_addr = aj[IW-1:0];
      E_RD:    s_addr = er[IW-1:0];
      default: s_addr = aj[IW-1:0];
    endcase
  end

  // Memories: one write port each, registered reads.
  always_ff @(posedge clk) begin
    if (state == IDLE && start && count < CW'(TASK_SLOTS)) begin
      tm_c[count[IW-1:0]] <= TB'(exec_time);
      tm_d[count[IW-1:0]] <= TB'(deadline);
      tm_t[count[IW-1:0]] <= t_in;
      tm_p[count[IW-1:0]] <= priority_req;
    end
    rda_c <= tm_c[si[IW-1:0]];
    rda_d <= tm_d[si[IW-1:0]];
    rda_t <= tm_t[si[IW-1:0]];
    rda_p <= tm_p[si[IW-1:0]];
    rdb_p <= tm_p[sj[IW-1:0]];

    if (state == S_CMPJ && sj == n - CW'(1)) begin
      sm_c[rank_final] <= rda_c;
      sm_d[rank_final] <= rda_d;
      sm_t[rank_final] <= rda_t;
      sm_i[rank_final] <= si[IW-1:0];
    end
    sq_c <= sm_c[s_addr];
    sq_d <= sm_d[s_addr];
    sq_t <= sm_t[s_addr];
    sq_i <= sm_i[s_addr];

    if (state == A_LDI && (sq_c > sq_d || ai == '0)) begin
      rm_r[ai[IW-1:0]] <= (sq_c > sq_d) ? '0 : sq_c;
      rm_m[ai[IW-1:0]] <= (sq_c > sq_d);
    end else if (state == A_ADD &&
                 (sum > SW'(di) || (aj + CW'(1) == ai && sum == SW'(resp)))) begin
      rm_r[ai[IW-1:0]] <= (sum > SW'(di)) ? '0 : resp;
      rm_m[ai[IW-1:0]] <= (sum > SW'(di));
    end
    rq_r <= rm_r[s_addr];
    rq_m <= rm_m[s_addr];
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      ovf   <= 1'b0;
      feas  <= 1'b1;
      valid <= 1'b0;
      last  <= 1'b0;
      si    <= '0;
      sj    <= '0;
    end else begin
      valid <= 1'b0;
      last  <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            count <= n_next;
            if (count == CW'(TASK_SLOTS)) begin
              ovf <= 1'b1;
            end
            if (last_task) begin
              n     <= n_next;
              si    <= '0;
              state <= S_RDI;
            end
          end
        end
        S_RDI: begin
          sj    <= '0;
          rank  <= '0;
          state <= S_RDJ;
        end
        S_RDJ: begin
          state <= S_CMPJ;
        end
        S_CMPJ: begin
          rank <= rank_final;
          if (sj == n - CW'(1)) begin
            if (si == n - CW'(1)) begin
              ai    <= '0;
              state <= A_RDI;
            end else begin
              si    <= si + CW'(1);
              state <= S_RDI;
            end
          end else begin
            sj    <= sj + CW'(1);
            state <= S_RDJ;
          end
        end
        A_RDI: begin
          state <= A_LDI;
        end
        A_LDI: begin
          ci   <= sq_c;
          di   <= sq_d;
          resp <= sq_c;
          nxt  <= SW'(sq_c);
          aj   <= '0;
          if (sq_c > sq_d || ai == '0) begin
            // Hold a miss, or the top-priority task, which converges at once.
            if (sq_c > sq_d) begin
              feas <= 1'b0;
            end
            if (ai + CW'(1) == n) begin
              er    <= '0;
              emit  <= (int'(n) < fprt_pkg::RESULT_CAP) ? n : CW'(fprt_pkg::RESULT_CAP);
              state <= E_RD;
            end else begin
              ai    <= ai + CW'(1);
              state <= A_RDI;
            end
          end else begin
            state <= A_RDJ;
          end
        end
        A_RDJ: begin
          state <= A_LDJ;
        end
        A_LDJ: begin
          cj    <= sq_c;
          state <= A_DIV;
        end
        A_DIV: begin
          if (div_st.done) begin
            q     <= div_quo[TB-1:0];
            state <= A_MUL;
          end
        end
        A_MUL: begin
          prod  <= (2*TB)'(q) * (2*TB)'(cj);
          state <= A_ADD;
        end
        A_ADD: begin
          if (sum > SW'(di) || (aj + CW'(1) == ai && sum == SW'(resp))) begin
            // Drop out on a miss or on a fixed point; advance the rank.
            if (sum > SW'(di)) begin
              feas <= 1'b0;
            end
            if (ai + CW'(1) == n) begin
              er    <= '0;
              emit  <= (int'(n) < fprt_pkg::RESULT_CAP) ? n : CW'(fprt_pkg::RESULT_CAP);
              state <= E_RD;
            end else begin
              ai    <= ai + CW'(1);
              state <= A_RDI;
            end
          end else if (aj + CW'(1) == ai) begin
            // Start the next iteration from the new estimate.
            resp  <= sum[TB-1:0];
            nxt   <= SW'(ci);
            aj    <= '0;
            state <= A_RDJ;
          end else begin
            nxt   <= sum;
            aj    <= aj + CW'(1);
            state <= A_RDJ;
          end
        end
        E_RD: begin
          state <= E_OUT;
        end
        E_OUT: begin
          valid         <= 1'b1;
          sorted_rank   <= 4'(er);
          task_index    <= 4'(sq_i);
          resp_ticks    <= 16'(rq_r);
          deadline_miss <= rq_m;
          all_feasible  <= feas;
          set_overflow  <= ovf;
          last          <= (er + CW'(1) == emit);
          if (er + CW'(1) == emit) begin
            count <= '0;
            ovf   <= 1'b0;
            feas  <= 1'b1;
            state <= IDLE;
          end else begin
            er    <= er + CW'(1);
            state <= E_RD;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A result strobe only follows an emit step.
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(state) == E_OUT)
    else $error("result strobe without emit step");

  // The final-result flag never stands alone.
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last |-> valid)
    else $error("last without valid");

  // Interference terms only come from higher-ranked tasks.
  a_term_rank: assert property (@(posedge clk) disable iff (rst)
    (state == A_ADD) |-> (aj < ai))
    else $error("interference from a lower-ranked task");

  // The divider is never restarted while a division is running.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

endmodule
